// ===== hdl/hpack_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpack_pkg
// Types, constants and the static code table for the HPACK Huffman encoder.
// ----------------------------------------------------------------------------
package hpack_pkg;

  localparam int MaxCodeBitsDef = 30;
  localparam int CountBitsDef   = 16;
  localparam int MaxBytes       = 5;

  typedef struct packed {
    logic [7:0] symbol;
    logic       final_symbol;
  } in_word_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       run_end;
    logic       string_end;
    logic       dropped;
  } out_word_t;

  // {length[4:0], code[29:0]}
  function automatic logic [34:0] code_lookup(input logic [7:0] s);
    logic [29:0] c;
    logic [4:0]  l;
    begin
      unique case (s)
        8'd0: begin c = 30'h1ff8; l = 5'd13; end
        8'd1: begin c = 30'h7fffd8; l = 5'd23; end
        8'd2: begin c = 30'hfffffe2; l = 5'd28; end
        8'd3: begin c = 30'hfffffe3; l = 5'd28; end
        8'd4: begin c = 30'hfffffe4; l = 5'd28; end
        8'd5: begin c = 30'hfffffe5; l = 5'd28; end
        8'd6: begin c = 30'hfffffe6; l = 5'd28; end
        8'd7: begin c = 30'hfffffe7; l = 5'd28; end
        8'd8: begin c = 30'hfffffe8; l = 5'd28; end
        8'd9: begin c = 30'hffffea; l = 5'd24; end
        8'd10: begin c = 30'h3ffffffc; l = 5'd30; end
        8'd11: begin c = 30'hfffffe9; l = 5'd28; end
        8'd12: begin c = 30'hfffffea; l = 5'd28; end
        8'd13: begin c = 30'h3ffffffd; l = 5'd30; end
        8'd14: begin c = 30'hfffffeb; l = 5'd28; end
        8'd15: begin c = 30'hfffffec; l = 5'd28; end
        8'd16: begin c = 30'hfffffed; l = 5'd28; end
        8'd17: begin c = 30'hfffffee; l = 5'd28; end
        8'd18: begin c = 30'hfffffef; l = 5'd28; end
        8'd19: begin c = 30'hffffff0; l = 5'd28; end
        8'd20: begin c = 30'hffffff1; l = 5'd28; end
        8'd21: begin c = 30'hffffff2; l = 5'd28; end
        8'd22: begin c = 30'h3ffffffe; l = 5'd30; end
        8'd23: begin c = 30'hffffff3; l = 5'd28; end
        8'd24: begin c = 30'hffffff4; l = 5'd28; end
        8'd25: begin c = 30'hffffff5; l = 5'd28; end
        8'd26: begin c = 30'hffffff6; l = 5'd28; end
        8'd27: begin c = 30'hffffff7; l = 5'd28; end
        8'd28: begin c = 30'hffffff8; l = 5'd28; end
        8'd29: begin c = 30'hffffff9; l = 5'd28; end
        8'd30: begin c = 30'hffffffa; l = 5'd28; end
        8'd31: begin c = 30'hffffffb; l = 5'd28; end
        8'd32: begin c = 30'h14; l = 5'd6; end
        8'd33: begin c = 30'h3f8; l = 5'd10; end
        8'd34: begin c = 30'h3f9; l = 5'd10; end
        8'd35: begin c = 30'hffa; l = 5'd12; end
        8'd36: begin c = 30'h1ff9; l = 5'd13; end
        8'd37: begin c = 30'h15; l = 5'd6; end
        8'd38: begin c = 30'hf8; l = 5'd8; end
        8'd39: begin c = 30'h7fa; l = 5'd11; end
        8'd40: begin c = 30'h3fa; l = 5'd10; end
        8'd41: begin c = 30'h3fb; l = 5'd10; end
        8'd42: begin c = 30'hf9; l = 5'd8; end
        8'd43: begin c = 30'h7fb; l = 5'd11; end
        8'd44: begin c = 30'hfa; l = 5'd8; end
        8'd45: begin c = 30'h16; l = 5'd6; end
        8'd46: begin c = 30'h17; l = 5'd6; end
        8'd47: begin c = 30'h18; l = 5'd6; end
        8'd48: begin c = 30'h0; l = 5'd5; end
        8'd49: begin c = 30'h1; l = 5'd5; end
        8'd50: begin c = 30'h2; l = 5'd5; end
        8'd51: begin c = 30'h19; l = 5'd6; end
        8'd52: begin c = 30'h1a; l = 5'd6; end
        8'd53: begin c = 30'h1b; l = 5'd6; end
        8'd54: begin c = 30'h1c; l = 5'd6; end
        8'd55: begin c = 30'h1d; l = 5'd6; end
        8'd56: begin c = 30'h1e; l = 5'd6; end
        8'd57: begin c = 30'h1f; l = 5'd6; end
        8'd58: begin c = 30'h5c; l = 5'd7; end
        8'd59: begin c = 30'hfb; l = 5'd8; end
        8'd60: begin c = 30'h7ffc; l = 5'd15; end
        8'd61: begin c = 30'h20; l = 5'd6; end
        8'd62: begin c = 30'hffb; l = 5'd12; end
        8'd63: begin c = 30'h3fc; l = 5'd10; end
        8'd64: begin c = 30'h1ffa; l = 5'd13; end
        8'd65: begin c = 30'h21; l = 5'd6; end
        8'd66: begin c = 30'h5d; l = 5'd7; end
        8'd67: begin c = 30'h5e; l = 5'd7; end
        8'd68: begin c = 30'h5f; l = 5'd7; end
        8'd69: begin c = 30'h60; l = 5'd7; end
        8'd70: begin c = 30'h61; l = 5'd7; end
        8'd71: begin c = 30'h62; l = 5'd7; end
        8'd72: begin c = 30'h63; l = 5'd7; end
        8'd73: begin c = 30'h64; l = 5'd7; end
        8'd74: begin c = 30'h65; l = 5'd7; end
        8'd75: begin c = 30'h66; l = 5'd7; end
        8'd76: begin c = 30'h67; l = 5'd7; end
        8'd77: begin c = 30'h68; l = 5'd7; end
        8'd78: begin c = 30'h69; l = 5'd7; end
        8'd79: begin c = 30'h6a; l = 5'd7; end
        8'd80: begin c = 30'h6b; l = 5'd7; end
        8'd81: begin c = 30'h6c; l = 5'd7; end
        8'd82: begin c = 30'h6d; l = 5'd7; end
        8'd83: begin c = 30'h6e; l = 5'd7; end
        8'd84: begin c = 30'h6f; l = 5'd7; end
        8'd85: begin c = 30'h70; l = 5'd7; end
        8'd86: begin c = 30'h71; l = 5'd7; end
        8'd87: begin c = 30'h72; l = 5'd7; end
        8'd88: begin c = 30'hfc; l = 5'd8; end
        8'd89: begin c = 30'h73; l = 5'd7; end
        8'd90: begin c = 30'hfd; l = 5'd8; end
        8'd91: begin c = 30'h1ffb; l = 5'd13; end
        8'd92: begin c = 30'h7fff0; l = 5'd19; end
        8'd93: begin c = 30'h1ffc; l = 5'd13; end
        8'd94: begin c = 30'h3ffc; l = 5'd14; end
        8'd95: begin c = 30'h22; l = 5'd6; end
        8'd96: begin c = 30'h7ffd; l = 5'd15; end
        8'd97: begin c = 30'h3; l = 5'd5; end
        8'd98: begin c = 30'h23; l = 5'd6; end
        8'd99: begin c = 30'h4; l = 5'd5; end
        8'd100: begin c = 30'h24; l = 5'd6; end
        8'd101: begin c = 30'h5; l = 5'd5; end
        8'd102: begin c = 30'h25; l = 5'd6; end
        8'd103: begin c = 30'h26; l = 5'd6; end
        8'd104: begin c = 30'h27; l = 5'd6; end
        8'd105: begin c = 30'h6; l = 5'd5; end
        8'd106: begin c = 30'h74; l = 5'd7; end
        8'd107: begin c = 30'h75; l = 5'd7; end
        8'd108: begin c = 30'h28; l = 5'd6; end
        8'd109: begin c = 30'h29; l = 5'd6; end
        8'd110: begin c = 30'h2a; l = 5'd6; end
        8'd111: begin c = 30'h7; l = 5'd5; end
        8'd112: begin c = 30'h2b; l = 5'd6; end
        8'd113: begin c = 30'h76; l = 5'd7; end
        8'd114: begin c = 30'h2c; l = 5'd6; end
        8'd115: begin c = 30'h8; l = 5'd5; end
        8'd116: begin c = 30'h9; l = 5'd5; end
        8'd117: begin c = 30'h2d; l = 5'd6; end
        8'd118: begin c = 30'h77; l = 5'd7; end
        8'd119: begin c = 30'h78; l = 5'd7; end
        8'd120: begin c = 30'h79; l = 5'd7; end
        8'd121: begin c = 30'h7a; l = 5'd7; end
        8'd122: begin c = 30'h7b; l = 5'd7; end
        8'd123: begin c = 30'h7ffe; l = 5'd15; end
        8'd124: begin c = 30'h7fc; l = 5'd11; end
        8'd125: begin c = 30'h3ffd; l = 5'd14; end
        8'd126: begin c = 30'h1ffd; l = 5'd13; end
        8'd127: begin c = 30'hffffffc; l = 5'd28; end
        8'd128: begin c = 30'hfffe6; l = 5'd20; end
        8'd129: begin c = 30'h3fffd2; l = 5'd22; end
        8'd130: begin c = 30'hfffe7; l = 5'd20; end
        8'd131: begin c = 30'hfffe8; l = 5'd20; end
        8'd132: begin c = 30'h3fffd3; l = 5'd22; end
        8'd133: begin c = 30'h3fffd4; l = 5'd22; end
        8'd134: begin c = 30'h3fffd5; l = 5'd22; end
        8'd135: begin c = 30'h7fffd9; l = 5'd23; end
        8'd136: begin c = 30'h3fffd6; l = 5'd22; end
        8'd137: begin c = 30'h7fffda; l = 5'd23; end
        8'd138: begin c = 30'h7fffdb; l = 5'd23; end
        8'd139: begin c = 30'h7fffdc; l = 5'd23; end
        8'd140: begin c = 30'h7fffdd; l = 5'd23; end
        8'd141: begin c = 30'h7fffde; l = 5'd23; end
        8'd142: begin c = 30'hffffeb; l = 5'd24; end
        8'd143: begin c = 30'h7fffdf; l = 5'd23; end
        8'd144: begin c = 30'hffffec; l = 5'd24; end
        8'd145: begin c = 30'hffffed; l = 5'd24; end
        8'd146: begin c = 30'h3fffd7; l = 5'd22; end
        8'd147: begin c = 30'h7fffe0; l = 5'd23; end
        8'd148: begin c = 30'hffffee; l = 5'd24; end
        8'd149: begin c = 30'h7fffe1; l = 5'd23; end
        8'd150: begin c = 30'h7fffe2; l = 5'd23; end
        8'd151: begin c = 30'h7fffe3; l = 5'd23; end
        8'd152: begin c = 30'h7fffe4; l = 5'd23; end
        8'd153: begin c = 30'h1fffdc; l = 5'd21; end
        8'd154: begin c = 30'h3fffd8; l = 5'd22; end
        8'd155: begin c = 30'h7fffe5; l = 5'd23; end
        8'd156: begin c = 30'h3fffd9; l = 5'd22; end
        8'd157: begin c = 30'h7fffe6; l = 5'd23; end
        8'd158: begin c = 30'h7fffe7; l = 5'd23; end
        8'd159: begin c = 30'hffffef; l = 5'd24; end
        8'd160: begin c = 30'h3fffda; l = 5'd22; end
        8'd161: begin c = 30'h1fffdd; l = 5'd21; end
        8'd162: begin c = 30'hfffe9; l = 5'd20; end
        8'd163: begin c = 30'h3fffdb; l = 5'd22; end
        8'd164: begin c = 30'h3fffdc; l = 5'd22; end
        8'd165: begin c = 30'h7fffe8; l = 5'd23; end
        8'd166: begin c = 30'h7fffe9; l = 5'd23; end
        8'd167: begin c = 30'h1fffde; l = 5'd21; end
        8'd168: begin c = 30'h7fffea; l = 5'd23; end
        8'd169: begin c = 30'h3fffdd; l = 5'd22; end
        8'd170: begin c = 30'h3fffde; l = 5'd22; end
        8'd171: begin c = 30'hfffff0; l = 5'd24; end
        8'd172: begin c = 30'h1fffdf; l = 5'd21; end
        8'd173: begin c = 30'h3fffdf; l = 5'd22; end
        8'd174: begin c = 30'h7fffeb; l = 5'd23; end
        8'd175: begin c = 30'h7fffec; l = 5'd23; end
        8'd176: begin c = 30'h1fffe0; l = 5'd21; end
        8'd177: begin c = 30'h1fffe1; l = 5'd21; end
        8'd178: begin c = 30'h3fffe0; l = 5'd22; end
        8'd179: begin c = 30'h1fffe2; l = 5'd21; end
        8'd180: begin c = 30'h7fffed; l = 5'd23; end
        8'd181: begin c = 30'h3fffe1; l = 5'd22; end
        8'd182: begin c = 30'h7fffee; l = 5'd23; end
        8'd183: begin c = 30'h7fffef; l = 5'd23; end
        8'd184: begin c = 30'hfffea; l = 5'd20; end
        8'd185: begin c = 30'h3fffe2; l = 5'd22; end
        8'd186: begin c = 30'h3fffe3; l = 5'd22; end
        8'd187: begin c = 30'h3fffe4; l = 5'd22; end
        8'd188: begin c = 30'h7ffff0; l = 5'd23; end
        8'd189: begin c = 30'h3fffe5; l = 5'd22; end
        8'd190: begin c = 30'h3fffe6; l = 5'd22; end
        8'd191: begin c = 30'h7ffff1; l = 5'd23; end
        8'd192: begin c = 30'h3ffffe0; l = 5'd26; end
        8'd193: begin c = 30'h3ffffe1; l = 5'd26; end
        8'd194: begin c = 30'hfffeb; l = 5'd20; end
        8'd195: begin c = 30'h7fff1; l = 5'd19; end
        8'd196: begin c = 30'h3fffe7; l = 5'd22; end
        8'd197: begin c = 30'h7ffff2; l = 5'd23; end
        8'd198: begin c = 30'h3fffe8; l = 5'd22; end
        8'd199: begin c = 30'h1ffffec; l = 5'd25; end
        8'd200: begin c = 30'h3ffffe2; l = 5'd26; end
        8'd201: begin c = 30'h3ffffe3; l = 5'd26; end
        8'd202: begin c = 30'h3ffffe4; l = 5'd26; end
        8'd203: begin c = 30'h7ffffde; l = 5'd27; end
        8'd204: begin c = 30'h7ffffdf; l = 5'd27; end
        8'd205: begin c = 30'h3ffffe5; l = 5'd26; end
        8'd206: begin c = 30'hfffff1; l = 5'd24; end
        8'd207: begin c = 30'h1ffffed; l = 5'd25; end
        8'd208: begin c = 30'h7fff2; l = 5'd19; end
        8'd209: begin c = 30'h1fffe3; l = 5'd21; end
        8'd210: begin c = 30'h3ffffe6; l = 5'd26; end
        8'd211: begin c = 30'h7ffffe0; l = 5'd27; end
        8'd212: begin c = 30'h7ffffe1; l = 5'd27; end
        8'd213: begin c = 30'h3ffffe7; l = 5'd26; end
        8'd214: begin c = 30'h7ffffe2; l = 5'd27; end
        8'd215: begin c = 30'hfffff2; l = 5'd24; end
        8'd216: begin c = 30'h1fffe4; l = 5'd21; end
        8'd217: begin c = 30'h1fffe5; l = 5'd21; end
        8'd218: begin c = 30'h3ffffe8; l = 5'd26; end
        8'd219: begin c = 30'h3ffffe9; l = 5'd26; end
        8'd220: begin c = 30'hffffffd; l = 5'd28; end
        8'd221: begin c = 30'h7ffffe3; l = 5'd27; end
        8'd222: begin c = 30'h7ffffe4; l = 5'd27; end
        8'd223: begin c = 30'h7ffffe5; l = 5'd27; end
        8'd224: begin c = 30'hfffec; l = 5'd20; end
        8'd225: begin c = 30'hfffff3; l = 5'd24; end
        8'd226: begin c = 30'hfffed; l = 5'd20; end
        8'd227: begin c = 30'h1fffe6; l = 5'd21; end
        8'd228: begin c = 30'h3fffe9; l = 5'd22; end
        8'd229: begin c = 30'h1fffe7; l = 5'd21; end
        8'd230: begin c = 30'h1fffe8; l = 5'd21; end
        8'd231: begin c = 30'h7ffff3; l = 5'd23; end
        8'd232: begin c = 30'h3fffea; l = 5'd22; end
        8'd233: begin c = 30'h3fffeb; l = 5'd22; end
        8'd234: begin c = 30'h1ffffee; l = 5'd25; end
        8'd235: begin c = 30'h1ffffef; l = 5'd25; end
        8'd236: begin c = 30'hfffff4; l = 5'd24; end
        8'd237: begin c = 30'hfffff5; l = 5'd24; end
        8'd238: begin c = 30'h3ffffea; l = 5'd26; end
        8'd239: begin c = 30'h7ffff4; l = 5'd23; end
        8'd240: begin c = 30'h3ffffeb; l = 5'd26; end
        8'd241: begin c = 30'h7ffffe6; l = 5'd27; end
        8'd242: begin c = 30'h3ffffec; l = 5'd26; end
        8'd243: begin c = 30'h3ffffed; l = 5'd26; end
        8'd244: begin c = 30'h7ffffe7; l = 5'd27; end
        8'd245: begin c = 30'h7ffffe8; l = 5'd27; end
        8'd246: begin c = 30'h7ffffe9; l = 5'd27; end
        8'd247: begin c = 30'h7ffffea; l = 5'd27; end
        8'd248: begin c = 30'h7ffffeb; l = 5'd27; end
        8'd249: begin c = 30'hffffffe; l = 5'd28; end
        8'd250: begin c = 30'h7ffffec; l = 5'd27; end
        8'd251: begin c = 30'h7ffffed; l = 5'd27; end
        8'd252: begin c = 30'h7ffffee; l = 5'd27; end
        8'd253: begin c = 30'h7ffffef; l = 5'd27; end
        8'd254: begin c = 30'h7fffff0; l = 5'd27; end
        default: begin c = 30'h3ffffee; l = 5'd26; end
      endcase
      return {l, c};
    end
  endfunction

endpackage

// ===== hdl/hpack_huffman_encoder_unit.sv =====
`timescale 1ns / 1ps
// A word's first byte is presented in the cycle after it is accepted.
// One word per cycle when each word makes at most one byte and out_ready is high;
//   a word that makes n bytes (up to five) holds the burst register until all are taken.
// Words that complete no byte leave nothing in the burst register.
// Reset (rst, synchronous): bit accumulator, byte count cleared; capacity 65535.
// ----------------------------------------------------------------------------
// hpack_huffman_encoder_unit
// HPACK static Huffman encoder: one octet in, whole code bytes out.
// ----------------------------------------------------------------------------
module hpack_huffman_encoder_unit #(
  parameter int MAX_CODE_BITS = hpack_pkg::MaxCodeBitsDef,
  parameter int COUNT_BITS    = hpack_pkg::CountBitsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hpack_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hpack_pkg::out_word_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);
  import hpack_pkg::*;

  // compare width covering both the byte count and the capacity
  localparam int CmpW = COUNT_BITS + 17;

  logic [15:0]         capacity;
  logic [3:0]          n_bytes;   // bytes held in the burst register
  logic [39:0]         bytes;
  logic                fin;
  logic [2:0]          idx;       // next byte of the burst to present
  logic [COUNT_BITS:0] written;   // bytes of the string so far, saturating
  logic                last;
  logic                load;
  logic                out_fire;

  assign cfg_ready = 1'b1;
  assign out_valid = (4'(idx) < n_bytes);
  assign last      = (4'(idx) + 4'd1 == n_bytes);
  assign out_fire  = out_valid && out_ready;
  // next word may load when the burst is empty or its last byte leaves now
  assign in_ready  = !out_valid || (out_fire && last);
  assign load      = in_valid && in_ready;

  hpack_packer #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_packer (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .in_word (in_data),
    .n_bytes (n_bytes),
    .bytes   (bytes),
    .fin     (fin)
  );

  always_comb begin
    out_data.code_byte  = bytes[39 - 8*32'(idx) -: 8];
    out_data.run_end    = last;
    out_data.string_end = last && fin;
    out_data.dropped    = (CmpW'(written) >= CmpW'(capacity));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 16'hffff;
      idx      <= '0;
      written  <= '0;
    end else begin
      if (cfg_valid) capacity <= cfg_data;
      if (load) idx <= '0;
      else if (out_fire) idx <= idx + 3'd1;
      if (out_fire) begin
        if (last && fin) written <= '0;
        else if (written[COUNT_BITS] == 1'b0) written <= written + (COUNT_BITS+1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_burst_bound: assert property (@(posedge clk) disable iff (rst)
    n_bytes <= 4'd5) else $error("burst too long");
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || (out_ready && last))) else $error("ready early");
  a_str_clear: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_data.string_end) |=> written == '0) else $error("count");
`endif

endmodule

// ===== hdl/hpack_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpack_packer
// Bit accumulator: appends one code per word and splits off whole bytes.
// Produces up to MaxBytes bytes per word into a small burst register.
// ----------------------------------------------------------------------------
module hpack_packer #(
  parameter int MAX_CODE_BITS = hpack_pkg::MaxCodeBitsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  hpack_pkg::in_word_t  in_word,
  output logic [3:0]           n_bytes,
  output logic [39:0]          bytes,
  output logic                 fin
);
  import hpack_pkg::*;

  localparam int LenW = $clog2(MAX_CODE_BITS + 1);
  // room for seven pending bits and the longest allowed code
  localparam int TotW = 40;

  logic [6:0]      acc;
  logic [2:0]      cnt;
  logic [34:0]     rom;
  logic [LenW-1:0] len;
  logic [29:0]     raw_code;
  logic [TotW-1:0] code;
  logic [TotW-1:0] mixed;
  logic [LenW:0]   total;
  logic [TotW+7:0] aligned;
  logic [2:0]      rem;
  logic [3:0]      whole;
  logic [TotW-1:0] tail_mask;
  logic [7:0]      pad_byte;
  logic [39:0]     bytes_next;
  logic [3:0]      n_next;
  logic [6:0]      acc_next;
  logic [2:0]      cnt_next;

  always_comb begin
    rom      = code_lookup(in_word.symbol);
    raw_code = rom[29:0];
    if (32'(rom[34:30]) > MAX_CODE_BITS) len = LenW'(MAX_CODE_BITS);
    else len = LenW'(rom[34:30]);
    code  = TotW'(raw_code) & ((TotW'(1) << len) - TotW'(1));
    mixed = (TotW'(acc) << len) | code;
    total = (LenW+1)'(len) + (LenW+1)'(cnt);
    whole = 4'(total >> 3);
    rem   = total[2:0];
    // left-justify so byte i sits at [TotW+7-8i -: 8]
    aligned = {mixed, 8'h00} << (TotW - 32'(total));
    bytes_next = aligned[TotW+7 -: 40];
    tail_mask  = (TotW'(1) << rem) - TotW'(1);
    pad_byte   = aligned[TotW+7 - 8*32'(whole) -: 8] | (8'hff >> rem);
    n_next   = whole;
    acc_next = 7'(mixed & tail_mask);
    cnt_next = rem;
    if (in_word.final_symbol) begin
      acc_next = '0;
      cnt_next = '0;
      if (rem != 3'd0) begin
        bytes_next[39 - 8*32'(whole) -: 8] = pad_byte;
        n_next = whole + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else if (load) begin
      acc <= acc_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_bytes <= '0;
    end else if (load) begin
      n_bytes <= n_next;
      bytes   <= bytes_next;
      fin     <= in_word.final_symbol;
    end
  end

endmodule
